// ----- rtl/box_downsample_rgba_assert.svh -----
// assertion macros used by bdr_back
// each expects i_clk and i_rst_n in scope
`ifndef BOX_DOWNSAMPLE_RGBA_ASSERT_SVH
`define BOX_DOWNSAMPLE_RGBA_ASSERT_SVH

// same-cycle implication
`define BDR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bdr_pkg.sv -----
package bdr_pkg;

    // fixed field widths
    localparam int PIX_W       = 8;
    localparam int PIX_MAX     = 255;
    localparam int NUM_CH      = 4;
    localparam int DCOL_W      = 12;
    localparam int SRC_DIM_W   = 13;
    localparam int FACTOR_CFG_W = 5;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_ADDR_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    // channel slots
    localparam int CH_ALPHA = 0;
    localparam int CH_RED   = 1;
    localparam int CH_GREEN = 2;
    localparam int CH_BLUE  = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FACTOR = 2'd2;

    // register reset values
    localparam logic [SRC_DIM_W-1:0]    RST_SRC_WIDTH  = 13'd256;
    localparam logic [SRC_DIM_W-1:0]    RST_SRC_HEIGHT = 13'd256;
    localparam logic [FACTOR_CFG_W-1:0] RST_FACTOR     = 5'd1;

    // per-segment flags handed from front to back
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic in_store;
        logic row_end;
        logic frame_end;
    } t_seg_flags;

    localparam int SEG_FLAGS_W = $bits(t_seg_flags);

    typedef enum logic [1:0] {
        G_LOAD,
        G_DIV,
        G_FIN,
        G_IDLE
    } t_geo_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ADD,
        B_DIV,
        B_PUSH
    } t_back_state;

endpackage

// ----- rtl/bdr_geom.sv -----
module bdr_geom #(
    parameter int MAX_SRC_WIDTH  = 4096,
    parameter int MAX_SRC_HEIGHT = 4096,
    parameter int MAX_FACTOR     = 16,
    localparam int WW    = $clog2(MAX_SRC_WIDTH + 1),
    localparam int HW    = $clog2(MAX_SRC_HEIGHT + 1),
    localparam int FW    = $clog2(MAX_FACTOR + 1),
    localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_ready,
    output logic [WW-1:0]                   o_w,
    output logic [HW-1:0]                   o_h,
    output logic [FW-1:0]                   o_bx,
    output logic [FW-1:0]                   o_by,
    output logic [WW-1:0]                   o_dw_m1,
    output logic [WW-1:0]                   o_col_lim,
    output logic [HW-1:0]                   o_row_lim,
    output logic [HW-1:0]                   o_row_last,
    output logic [CNT_W-1:0]                o_cnt
);
    import bdr_pkg::*;

    localparam int NB = (WW > HW) ? WW : HW;
    localparam int SW = $clog2(NB + 1);

    logic [SRC_DIM_W-1:0]    r_src_width;
    logic [SRC_DIM_W-1:0]    r_src_height;
    logic [FACTOR_CFG_W-1:0] r_block_factor;

    t_geo_state r_state, n_state;

    logic [WW-1:0] w_c;
    logic [HW-1:0] h_c;
    logic [FW-1:0] f_c;
    logic [FW-1:0] bx_c;
    logic [FW-1:0] by_c;

    logic [NB-1:0] r_dvd_w, r_dvd_h;
    logic [FW-1:0] r_rem_w, r_rem_h;
    logic [SW-1:0] r_step;

    logic [FW:0]   trial_w, trial_h;
    logic          ge_w, ge_h;
    logic [WW-1:0] qw;
    logic [HW-1:0] qh;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= RST_SRC_WIDTH;
            r_src_height   <= RST_SRC_HEIGHT;
            r_block_factor <= RST_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IDX_WIDTH:  r_src_width    <= i_cfg_data;
                CFG_IDX_HEIGHT: r_src_height   <= i_cfg_data;
                CFG_IDX_FACTOR: r_block_factor <= i_cfg_data[FACTOR_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to legal range
    always_comb begin
        if (r_src_width == '0)
            w_c = WW'(1);
        else if (32'(r_src_width) > MAX_SRC_WIDTH)
            w_c = WW'(MAX_SRC_WIDTH);
        else
            w_c = WW'(r_src_width);

        if (r_src_height == '0)
            h_c = HW'(1);
        else if (32'(r_src_height) > MAX_SRC_HEIGHT)
            h_c = HW'(MAX_SRC_HEIGHT);
        else
            h_c = HW'(r_src_height);

        if (r_block_factor == '0)
            f_c = FW'(1);
        else if (32'(r_block_factor) > MAX_FACTOR)
            f_c = FW'(MAX_FACTOR);
        else
            f_c = FW'(r_block_factor);

        bx_c = (32'(f_c) < 32'(w_c)) ? f_c : FW'(w_c);
        by_c = (32'(f_c) < 32'(h_c)) ? f_c : FW'(h_c);
    end

    // one quotient bit per cycle for both dimensions
    always_comb begin
        trial_w = {r_rem_w, r_dvd_w[NB-1]};
        trial_h = {r_rem_h, r_dvd_h[NB-1]};
        ge_w    = trial_w >= {1'b0, f_c};
        ge_h    = trial_h >= {1'b0, f_c};
        qw      = WW'(r_dvd_w);
        qh      = HW'(r_dvd_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= G_LOAD;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_LOAD: n_state = G_DIV;
            G_DIV:  if (r_step == SW'(1)) n_state = G_FIN;
            G_FIN:  n_state = G_IDLE;
            G_IDLE: n_state = G_IDLE;
            default: n_state = G_LOAD;
        endcase
        if (i_cfg_we)
            n_state = G_LOAD;
    end

    assign o_ready = (r_state == G_IDLE);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            G_LOAD: begin
                r_dvd_w <= NB'(w_c);
                r_dvd_h <= NB'(h_c);
                r_rem_w <= '0;
                r_rem_h <= '0;
                r_step  <= SW'(NB);
            end
            G_DIV: begin
                r_rem_w <= ge_w ? FW'(trial_w - {1'b0, f_c}) : FW'(trial_w);
                r_rem_h <= ge_h ? FW'(trial_h - {1'b0, f_c}) : FW'(trial_h);
                r_dvd_w <= {r_dvd_w[NB-2:0], ge_w};
                r_dvd_h <= {r_dvd_h[NB-2:0], ge_h};
                r_step  <= r_step - SW'(1);
            end
            G_FIN: begin
                o_w        <= w_c;
                o_h        <= h_c;
                o_bx       <= bx_c;
                o_by       <= by_c;
                o_dw_m1    <= (qw == '0) ? '0 : qw - WW'(1);
                o_col_lim  <= (qw == '0) ? w_c : w_c - WW'(r_rem_w);
                o_row_lim  <= (qh == '0) ? h_c : h_c - HW'(r_rem_h);
                o_row_last <= (qh == '0) ? h_c - HW'(1) : h_c - HW'(r_rem_h) - HW'(1);
                o_cnt      <= CNT_W'(bx_c) * CNT_W'(by_c);
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/bdr_front.sv -----
module bdr_front #(
    parameter int MAX_SRC_WIDTH  = 4096,
    parameter int MAX_SRC_HEIGHT = 4096,
    parameter int MAX_FACTOR     = 16,
    localparam int WW   = $clog2(MAX_SRC_WIDTH + 1),
    localparam int HW   = $clog2(MAX_SRC_HEIGHT + 1),
    localparam int FW   = $clog2(MAX_FACTOR + 1),
    localparam int RS_W = $clog2(MAX_FACTOR * bdr_pkg::PIX_MAX + 1)
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic                                           i_frame_start,
    input  logic [bdr_pkg::PIX_W-1:0]                      i_in_alpha,
    input  logic [bdr_pkg::PIX_W-1:0]                      i_in_red,
    input  logic [bdr_pkg::PIX_W-1:0]                      i_in_green,
    input  logic [bdr_pkg::PIX_W-1:0]                      i_in_blue,
    input  logic                                           i_geom_ready,
    input  logic [WW-1:0]                                  i_w,
    input  logic [HW-1:0]                                  i_h,
    input  logic [FW-1:0]                                  i_bx,
    input  logic [FW-1:0]                                  i_by,
    input  logic [WW-1:0]                                  i_dw_m1,
    input  logic [WW-1:0]                                  i_col_lim,
    input  logic [HW-1:0]                                  i_row_lim,
    input  logic [HW-1:0]                                  i_row_last,
    input  logic                                           i_q_full,
    output logic                                           o_push,
    output bdr_pkg::t_seg_flags                            o_flags,
    output logic [bdr_pkg::DCOL_W-1:0]                     o_dcol,
    output logic [bdr_pkg::NUM_CH-1:0][RS_W-1:0]           o_sum
);
    import bdr_pkg::*;

    localparam int CW = $clog2(MAX_FACTOR);

    logic [WW-1:0]                 r_src_col, n_src_col, base_col, col_inc;
    logic [HW-1:0]                 r_src_row, n_src_row, base_row, row_inc;
    logic [CW-1:0]                 r_cib, n_cib, base_cib;
    logic [CW-1:0]                 r_rib, n_rib, base_rib;
    logic [DCOL_W-1:0]             r_dcol, n_dcol, base_dcol;
    logic [NUM_CH-1:0][RS_W-1:0]   r_sum, n_sum, base_sum, rs_new;
    logic [NUM_CH-1:0][PIX_W-1:0]  px;
    logic                          accept, in_reg, seg_end;

    assign o_ready = i_geom_ready && !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        px[CH_ALPHA] = i_in_alpha;
        px[CH_RED]   = i_in_red;
        px[CH_GREEN] = i_in_green;
        px[CH_BLUE]  = i_in_blue;

        // frame start clears position before the pixel is taken
        base_col  = i_frame_start ? '0 : r_src_col;
        base_row  = i_frame_start ? '0 : r_src_row;
        base_cib  = i_frame_start ? '0 : r_cib;
        base_rib  = i_frame_start ? '0 : r_rib;
        base_dcol = i_frame_start ? '0 : r_dcol;
        base_sum  = i_frame_start ? '0 : r_sum;

        in_reg  = (base_col < i_col_lim) && (base_row < i_row_lim);
        seg_end = FW'(base_cib) >= (i_bx - FW'(1));

        for (int c = 0; c < NUM_CH; c++)
            rs_new[c] = (base_cib == '0 ? '0 : base_sum[c]) + RS_W'(px[c]);
        n_sum = in_reg ? rs_new : base_sum;

        o_flags.first_row = (base_rib == '0);
        o_flags.last_row  = FW'(base_rib) >= (i_by - FW'(1));
        o_flags.in_store  = 32'(base_dcol) < MAX_SRC_WIDTH;
        o_flags.row_end   = 32'(base_dcol) >= 32'(i_dw_m1);
        o_flags.frame_end = o_flags.row_end && (base_row >= i_row_last);
        o_dcol            = base_dcol;
        o_sum             = rs_new;
        o_push            = accept && in_reg && seg_end;

        // position advance
        col_inc = base_col + WW'(1);
        row_inc = base_row + HW'(1);
        if (seg_end) begin
            n_cib  = '0;
            n_dcol = base_dcol + DCOL_W'(1);
        end else begin
            n_cib  = base_cib + CW'(1);
            n_dcol = base_dcol;
        end
        n_src_col = col_inc;
        n_src_row = base_row;
        n_rib     = base_rib;
        if (col_inc >= i_w) begin
            n_src_col = '0;
            n_cib     = '0;
            n_dcol    = '0;
            n_src_row = row_inc;
            n_rib     = (FW'(base_rib) >= (i_by - FW'(1))) ? '0 : base_rib + CW'(1);
            if (row_inc >= i_h) begin
                n_src_row = '0;
                n_rib     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_cib     <= '0;
            r_rib     <= '0;
            r_dcol    <= '0;
            r_sum     <= '0;
        end else if (accept) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_cib     <= n_cib;
            r_rib     <= n_rib;
            r_dcol    <= n_dcol;
            r_sum     <= n_sum;
        end
    end

endmodule

// ----- rtl/bdr_fifo.sv -----
module bdr_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW:0]      r_wr_ptr, r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[PW-1:0] == r_rd_ptr[PW-1:0]) && (r_wr_ptr[PW] != r_rd_ptr[PW]);
    assign o_data  = r_mem[r_rd_ptr[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + (PW+1)'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr[PW-1:0]] <= i_data;
    end

endmodule

// ----- rtl/bdr_back.sv -----
`include "box_downsample_rgba_assert.svh"

module bdr_back #(
    parameter int MAX_SRC_WIDTH = 4096,
    parameter int MAX_FACTOR    = 16,
    localparam int RS_W  = $clog2(MAX_FACTOR * bdr_pkg::PIX_MAX + 1),
    localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_op_valid,
    output logic                                 o_op_ready,
    input  bdr_pkg::t_seg_flags                  i_op_flags,
    input  logic [bdr_pkg::DCOL_W-1:0]           i_op_dcol,
    input  logic [bdr_pkg::NUM_CH-1:0][RS_W-1:0] i_op_sum,
    input  logic [CNT_W-1:0]                     i_cnt,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bdr_pkg::PIX_W-1:0]            o_out_alpha,
    output logic [bdr_pkg::PIX_W-1:0]            o_out_red,
    output logic [bdr_pkg::PIX_W-1:0]            o_out_green,
    output logic [bdr_pkg::PIX_W-1:0]            o_out_blue,
    output logic                                 o_row_end,
    output logic                                 o_frame_end
);
    import bdr_pkg::*;

    localparam int SUM_W = $clog2(MAX_FACTOR * MAX_FACTOR * PIX_MAX + 1);
    localparam int AW    = $clog2(MAX_SRC_WIDTH);
    localparam int SW    = $clog2(SUM_W + 1);

    t_back_state r_state, n_state;

    logic [NUM_CH-1:0][SUM_W-1:0]  r_mem [MAX_SRC_WIDTH];
    logic [NUM_CH-1:0][SUM_W-1:0]  r_rdata;
    logic [NUM_CH-1:0][SUM_W-1:0]  tot;
    logic                          mem_we;

    t_seg_flags                    r_flags;
    logic [DCOL_W-1:0]             r_dcol;
    logic [NUM_CH-1:0][RS_W-1:0]   r_sum;
    logic [CNT_W-1:0]              r_cnt;

    logic [NUM_CH-1:0][SUM_W-1:0]  r_dvd;
    logic [NUM_CH-1:0][CNT_W-1:0]  r_rem;
    logic [NUM_CH-1:0][PIX_W-1:0]  r_quo;
    logic [NUM_CH-1:0][CNT_W:0]    trial;
    logic [NUM_CH-1:0]             ge;
    logic [SW-1:0]                 r_step;

    logic                          pop, out_load, r_out_valid, n_out_valid;
    logic [NUM_CH-1:0][PIX_W-1:0]  r_out_pix;
    logic                          r_out_row_end, r_out_frame_end;

    assign o_op_ready = (r_state == B_IDLE);
    assign pop        = i_op_valid && o_op_ready;

    // accumulate onto the stored column sums, from zero on the first block row or outside the store
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            tot[c] = ((r_flags.first_row || !r_flags.in_store) ? '0 : r_rdata[c])
                     + SUM_W'(r_sum[c]);
            trial[c] = {r_rem[c], r_dvd[c][SUM_W-1]};
            ge[c]    = trial[c] >= {1'b0, r_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            B_IDLE: if (pop) n_state = B_ADD;
            B_ADD: begin
                if (r_flags.last_row) begin
                    n_state = B_DIV;
                end else begin
                    mem_we  = r_flags.in_store;
                    n_state = B_IDLE;
                end
            end
            B_DIV: if (r_step == SW'(1)) n_state = B_PUSH;
            B_PUSH: begin
                if (!r_out_valid || i_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[AW'(r_dcol)] <= tot;
        if (pop)
            r_rdata <= r_mem[AW'(i_op_dcol)];
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_flags <= i_op_flags;
            r_dcol  <= i_op_dcol;
            r_sum   <= i_op_sum;
            r_cnt   <= i_cnt;
        end
        if (r_state == B_ADD) begin
            r_dvd  <= tot;
            r_rem  <= '0;
            r_step <= SW'(SUM_W);
        end else if (r_state == B_DIV) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_rem[c] <= ge[c] ? CNT_W'(trial[c] - {1'b0, r_cnt}) : CNT_W'(trial[c]);
                r_dvd[c] <= {r_dvd[c][SUM_W-2:0], 1'b0};
                r_quo[c] <= {r_quo[c][PIX_W-2:0], ge[c]};
            end
            r_step <= r_step - SW'(1);
        end
        if (out_load) begin
            r_out_pix       <= r_quo;
            r_out_row_end   <= r_flags.row_end;
            r_out_frame_end <= r_flags.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_alpha = r_out_pix[CH_ALPHA];
    assign o_out_red   = r_out_pix[CH_RED];
    assign o_out_green = r_out_pix[CH_GREEN];
    assign o_out_blue  = r_out_pix[CH_BLUE];
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

    `BDR_ASSERT_IMP(a_rem_below_cnt, r_state == B_DIV,
        (r_cnt != '0) && (r_rem[CH_ALPHA] < r_cnt) && (r_rem[CH_RED] < r_cnt)
        && (r_rem[CH_GREEN] < r_cnt) && (r_rem[CH_BLUE] < r_cnt),
        "divider remainder reached divisor")
    `BDR_ASSERT_IMP(a_add_after_pop, r_state == B_ADD, $past(pop),
        "line store add without a popped segment")
    `BDR_ASSERT_NXT(a_last_row_divides, (r_state == B_ADD) && r_flags.last_row,
        (r_state == B_DIV) && !$past(mem_we), "last block row did not divide")
    `BDR_ASSERT_IMP(a_frame_end_row_end, r_out_valid, !r_out_frame_end || r_out_row_end,
        "frame end without row end")

endmodule

// ----- rtl/box_downsample_rgba.sv -----
// box downsampler for rgba pixels
// input channel: i_valid/o_ready, one source pixel per transfer in raster order,
//   i_frame_start marks the first pixel of a frame and restarts the position
// output channel: o_valid/i_ready, one averaged pixel per transfer with row and
//   frame end marks; each channel is the block sum divided by the pixel count
// config port: i_cfg_we writes i_cfg_addr (0 width, 1 height, 2 factor) at once
// a pixel that does not close a block segment is handled by the front end alone;
//   one that closes a segment on an upper block row costs the back end a line
//   store read then write; one that closes a block also goes through the
//   bit-serial divider; a four-deep queue absorbs bursts
// after reset and after every config write the geometry unit divides width and
//   height by the factor one bit a cycle, holding o_ready low until it finishes;
//   no clearing pass, line store entries are written before read
// a stalled receiver holds the result in the output register; the back end and
//   then the queue fill up before o_ready drops
module box_downsample_rgba #(
    parameter int MAX_SRC_WIDTH  = 4096,
    parameter int MAX_SRC_HEIGHT = 4096,
    parameter int MAX_FACTOR     = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_frame_start,
    input  logic [bdr_pkg::PIX_W-1:0]       i_in_alpha,
    input  logic [bdr_pkg::PIX_W-1:0]       i_in_red,
    input  logic [bdr_pkg::PIX_W-1:0]       i_in_green,
    input  logic [bdr_pkg::PIX_W-1:0]       i_in_blue,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bdr_pkg::PIX_W-1:0]       o_out_alpha,
    output logic [bdr_pkg::PIX_W-1:0]       o_out_red,
    output logic [bdr_pkg::PIX_W-1:0]       o_out_green,
    output logic [bdr_pkg::PIX_W-1:0]       o_out_blue,
    output logic                            o_row_end,
    output logic                            o_frame_end
);
    import bdr_pkg::*;

    localparam int WW    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HW    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int RS_W  = $clog2(MAX_FACTOR * PIX_MAX + 1);
    localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    // queue entry: flags, output column, four row segment sums
    localparam int Q_W   = SEG_FLAGS_W + DCOL_W + NUM_CH * RS_W;

    // geometry derived from the registers
    logic                 w_geom_ready;
    logic [WW-1:0]        w_w, w_dw_m1, w_col_lim;
    logic [HW-1:0]        w_h, w_row_lim, w_row_last;
    logic [FW-1:0]        w_bx, w_by;
    logic [CNT_W-1:0]     w_cnt;

    // front to queue
    logic                         w_push;
    t_seg_flags                   w_flags;
    logic [DCOL_W-1:0]            w_dcol;
    logic [NUM_CH-1:0][RS_W-1:0]  w_sum;

    // queue to back
    logic                         w_q_full, w_q_empty, w_pop, w_op_ready;
    logic [Q_W-1:0]               w_q_wdata, w_q_rdata;
    t_seg_flags                   w_op_flags;
    logic [DCOL_W-1:0]            w_op_dcol;
    logic [NUM_CH-1:0][RS_W-1:0]  w_op_sum;

    bdr_geom #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_FACTOR     (MAX_FACTOR)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_ready    (w_geom_ready),
        .o_w        (w_w),
        .o_h        (w_h),
        .o_bx       (w_bx),
        .o_by       (w_by),
        .o_dw_m1    (w_dw_m1),
        .o_col_lim  (w_col_lim),
        .o_row_lim  (w_row_lim),
        .o_row_last (w_row_last),
        .o_cnt      (w_cnt)
    );

    // position tracking and row segment sums
    bdr_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_FACTOR     (MAX_FACTOR)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_frame_start (i_frame_start),
        .i_in_alpha    (i_in_alpha),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_geom_ready  (w_geom_ready),
        .i_w           (w_w),
        .i_h           (w_h),
        .i_bx          (w_bx),
        .i_by          (w_by),
        .i_dw_m1       (w_dw_m1),
        .i_col_lim     (w_col_lim),
        .i_row_lim     (w_row_lim),
        .i_row_last    (w_row_last),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_flags       (w_flags),
        .o_dcol        (w_dcol),
        .o_sum         (w_sum)
    );

    assign w_q_wdata = {w_flags, w_dcol, w_sum};

    // decouples the pixel stream from line store and divider work
    bdr_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    assign w_op_flags = t_seg_flags'(w_q_rdata[Q_W-1 -: SEG_FLAGS_W]);
    assign w_op_dcol  = w_q_rdata[NUM_CH*RS_W +: DCOL_W];
    assign w_op_sum   = w_q_rdata[NUM_CH*RS_W-1:0];
    assign w_pop      = !w_q_empty && w_op_ready;

    // line store accumulate, divide and output register
    bdr_back #(
        .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
        .MAX_FACTOR    (MAX_FACTOR)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (!w_q_empty),
        .o_op_ready  (w_op_ready),
        .i_op_flags  (w_op_flags),
        .i_op_dcol   (w_op_dcol),
        .i_op_sum    (w_op_sum),
        .i_cnt       (w_cnt),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_alpha (o_out_alpha),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

endmodule
